// ----- hw/rtl/ama_pkg.sv -----
// Package for the adaptive moving average block: widths, fixed-point
// constants and the controller/datapath command and status structs.
// No dependencies.
`default_nettype none

package ama_pkg;

  localparam int DATA_W         = 32;
  localparam int PER_W          = 7;
  localparam int CNT_W          = 8;
  localparam int SUM_W          = 40;
  localparam int ER_W           = 17;
  localparam int FRAC_W         = 16;
  localparam int PERIOD_MAX_DEF = 64;
  localparam int PERIOD_RESET   = 10;
  localparam int FAST_Q16       = 43691;
  localparam int SLOW_Q16       = 4228;
  localparam int ONE_Q16        = 65536;
  localparam int DIV_STEPS      = 16;

  // window read selector
  localparam logic [1:0] RD_BACK1  = 2'd0;
  localparam logic [1:0] RD_BACKP  = 2'd1;
  localparam logic [1:0] RD_BACKP1 = 2'd2;

  typedef struct packed {
    logic       load;
    logic [1:0] rd_sel;
    logic       acc_add;
    logic       latch_xp;
    logic       acc_sub;
    logic       seed;
    logic       div_init;
    logic       div_step;
    logic       mul1;
    logic       mul2;
    logic       mul3;
    logic       upd;
    logic       commit;
  } cmd_t;

  typedef struct packed {
    logic seed;
    logic upd;
    logic div_sat;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/adaptive_moving_average.sv -----
// Top level of the adaptive moving average (Kaufman style) block.
// Depends on ama_pkg, ama_ctrl and ama_dp.
`default_nettype none

//  channel  | ports                      | payload
//  ---------+----------------------------+------------------------------------
//  input    | in_tvalid/in_tready        | tdata: sample Q16.16; tuser: series_start
//  result   | out_tvalid/out_tready      | tdata: average Q16.16
//  config   | cfg_wen/cfg_wdata          | window_period, 7 bits
//
// A word that yields nothing or seeds the average passes through four window
// memory read states; a full update adds 16 steps of the restoring divider
// for the efficiency ratio (skipped when it saturates) and three registered
// multiplies. Reset (rst_n low, synchronous) sets the period to 10 and
// clears the sum, count and average. The result sits in an output register;
// a stalled result only holds the next word at its finish.

module adaptive_moving_average #(
  parameter int PERIOD_MAX = ama_pkg::PERIOD_MAX_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_tvalid,
  output logic                         in_tready,
  input  wire  [ama_pkg::DATA_W-1:0]   in_tdata,   // [31:0] sample
  input  wire                          in_tuser,   // [0] series_start
  output logic                         out_tvalid,
  input  wire                          out_tready,
  output logic [ama_pkg::DATA_W-1:0]   out_tdata,  // [31:0] average
  input  wire                          cfg_wen,
  input  wire  [ama_pkg::PER_W-1:0]    cfg_wdata
);

  ama_pkg::cmd_t cmd;
  ama_pkg::sts_t sts;

  // sequence each word through read, divide, multiply and commit steps
  ama_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // window, running sum, divider, multipliers and result register
  ama_dp #(
    .PERIOD_MAX (PERIOD_MAX)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/ama_ctrl.sv -----
// Controller state machine for the adaptive moving average.
// Depends on ama_pkg; drives ama_dp through cmd_t, reads sts_t.
`default_nettype none

module ama_ctrl (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_tvalid,
  output logic             in_tready,
  input  ama_pkg::sts_t    sts,
  output ama_pkg::cmd_t    cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD1  = 4'd1;
  localparam logic [3:0] S_RD2  = 4'd2;
  localparam logic [3:0] S_RD3  = 4'd3;
  localparam logic [3:0] S_RD4  = 4'd4;
  localparam logic [3:0] S_DEC  = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_MUL1 = 4'd7;
  localparam logic [3:0] S_MUL2 = 4'd8;
  localparam logic [3:0] S_MUL3 = 4'd9;
  localparam logic [3:0] S_UPD  = 4'd10;
  localparam logic [3:0] S_DONE = 4'd11;

  logic [3:0] state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    in_tready = 1'b0;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_RD1;
        end
      end
      S_RD1: begin
        cmd.rd_sel = ama_pkg::RD_BACK1;
        state_nxt  = S_RD2;
      end
      S_RD2: begin
        cmd.acc_add = 1'b1;
        cmd.rd_sel  = ama_pkg::RD_BACKP;
        state_nxt   = S_RD3;
      end
      S_RD3: begin
        cmd.latch_xp = 1'b1;
        cmd.rd_sel   = ama_pkg::RD_BACKP1;
        state_nxt    = S_RD4;
      end
      S_RD4: begin
        cmd.acc_sub = 1'b1;
        state_nxt   = S_DEC;
      end
      S_DEC: begin
        if (sts.seed) begin
          cmd.seed  = 1'b1;
          state_nxt = S_DONE;
        end else if (sts.upd) begin
          cmd.div_init = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = sts.div_sat ? S_MUL1 : S_DIV;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 5'd1;
        if (cnt_r == 5'(ama_pkg::DIV_STEPS - 1)) state_nxt = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_MUL3;
      end
      S_MUL3: begin
        cmd.mul3  = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ama_dp.sv -----
// Datapath for the adaptive moving average: sample window memory, difference
// sum, serial divider, multipliers and output register. Depends on ama_pkg.
`default_nettype none

module ama_dp #(
  parameter int PERIOD_MAX = ama_pkg::PERIOD_MAX_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire  [ama_pkg::DATA_W-1:0]       in_tdata,
  input  wire                              in_tuser,
  input  wire                              cfg_wen,
  input  wire  [ama_pkg::PER_W-1:0]        cfg_wdata,
  input  ama_pkg::cmd_t                    cmd,
  output ama_pkg::sts_t                    sts,
  output logic                             out_tvalid,
  input  wire                              out_tready,
  output logic [ama_pkg::DATA_W-1:0]       out_tdata
);

  localparam int DW    = ama_pkg::DATA_W;
  localparam int CW    = ama_pkg::CNT_W;
  localparam int SW    = ama_pkg::SUM_W;
  localparam int EW    = ama_pkg::ER_W;
  localparam int FW    = ama_pkg::FRAC_W;
  localparam int DEPTH = PERIOD_MAX + 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IW    = ((AW > CW) ? AW : CW) + 1;
  localparam int PW    = 2 * DW + 2;

  // signed 32-bit limits in the width of the widened average
  localparam logic signed [DW+2:0] NAV_MAX = {4'b0000, {(DW-1){1'b1}}};
  localparam logic signed [DW+2:0] NAV_MIN = {4'b1111, {(DW-1){1'b0}}};

  logic [DW-1:0] mem [DEPTH];

  logic [ama_pkg::PER_W-1:0] period_r;
  logic [CW-1:0]             cnt_r, n_r;
  logic [AW-1:0]             wp_r;
  logic [SW-1:0]             sum_r;
  logic signed [DW-1:0]      x_r, xp_r, avg_r, out_r;
  logic                      out_vld_r, prod_r;
  logic [DW-1:0]             rd_r;
  logic [SW:0]               rem_r;
  logic [EW-1:0]             er_r;
  logic [FW-1:0]             base_r, sc_r;
  logic signed [PW-1:0]      prod_mul_r;

  // effective period, clamped to 1..PERIOD_MAX
  logic [CW-1:0] p_eff;
  always_comb begin
    if (period_r == '0) p_eff = CW'(1);
    else if (int'(period_r) > PERIOD_MAX) p_eff = CW'(PERIOD_MAX);
    else p_eff = CW'(period_r);
  end

  // window address k entries back from the write pointer
  logic [IW-1:0] k, idx_t, idx_w;
  always_comb begin
    case (cmd.rd_sel)
      ama_pkg::RD_BACK1:  k = IW'(1);
      ama_pkg::RD_BACKP:  k = IW'(p_eff);
      ama_pkg::RD_BACKP1: k = IW'(p_eff) + IW'(1);
      default:            k = IW'(1);
    endcase
    idx_t = IW'(wp_r) + IW'(DEPTH) - k;
    idx_w = (idx_t >= IW'(DEPTH)) ? idx_t - IW'(DEPTH) : idx_t;
  end

  always_ff @(posedge clk) begin
    rd_r <= mem[idx_w[AW-1:0]];
    if (cmd.commit) mem[wp_r] <= x_r;
  end

  // absolute differences on sign-extended samples
  logic signed [DW:0] d_add, d_sub, d_net;
  logic [DW:0]        a_add, a_sub, a_net;
  always_comb begin
    d_add = {x_r[DW-1], x_r} - {rd_r[DW-1], rd_r};
    d_sub = {xp_r[DW-1], xp_r} - {rd_r[DW-1], rd_r};
    d_net = {x_r[DW-1], x_r} - {xp_r[DW-1], xp_r};
    a_add = d_add[DW] ? (DW+1)'(-d_add) : (DW+1)'(d_add);
    a_sub = d_sub[DW] ? (DW+1)'(-d_sub) : (DW+1)'(d_sub);
    a_net = d_net[DW] ? (DW+1)'(-d_net) : (DW+1)'(d_net);
  end

  logic [SW:0] rem2;
  assign rem2 = {rem_r[SW-1:0], 1'b0};

  // multiplier operands
  localparam int FMS = ama_pkg::FAST_Q16 - ama_pkg::SLOW_Q16;
  logic [EW+FW-1:0]      m1;
  logic [2*FW-1:0]       m2;
  logic signed [DW+1:0]  diff;
  logic signed [PW-1:0]  rnd;
  logic signed [PW-FW-1:0] step;
  logic signed [DW+2:0]  nav;
  always_comb begin
    m1   = (EW+FW)'(er_r) * (EW+FW)'(FMS) + (EW+FW)'(32768);
    m2   = (2*FW)'(base_r) * (2*FW)'(base_r) + (2*FW)'(32768);
    diff = (DW+2)'(x_r) - (DW+2)'(avg_r);
    rnd  = prod_mul_r + PW'(32768);
    step = rnd[PW-1:FW];
    nav  = (DW+3)'(avg_r) + (DW+3)'(step);
  end

  assign sts.seed     = ({1'b0, n_r} + (CW+1)'(1)) == {1'b0, p_eff};
  assign sts.upd      = n_r >= p_eff;
  assign sts.div_sat  = (sum_r == '0) || (SW'(a_net) >= sum_r);
  assign sts.out_free = !out_vld_r || out_tready;

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r  <= ama_pkg::PER_W'(ama_pkg::PERIOD_RESET);
      cnt_r     <= '0;
      sum_r     <= '0;
      wp_r      <= '0;
      avg_r     <= '0;
      out_vld_r <= 1'b0;
      prod_r    <= 1'b0;
    end else begin
      if (cmd.commit && prod_r) out_vld_r <= 1'b1;
      else if (out_tready) out_vld_r <= 1'b0;
      if (cfg_wen) begin
        period_r <= cfg_wdata;
        cnt_r    <= '0;
        sum_r    <= '0;
      end
      if (cmd.load) begin
        prod_r <= 1'b0;
        if (in_tuser) begin
          n_r   <= '0;
          cnt_r <= '0;
          sum_r <= '0;
        end else begin
          n_r <= cnt_r;
        end
      end
      if (cmd.acc_add && n_r != '0) sum_r <= sum_r + SW'(a_add);
      if (cmd.acc_sub && n_r > p_eff)
        sum_r <= (sum_r >= SW'(a_sub)) ? sum_r - SW'(a_sub) : '0;
      if (cmd.seed) begin
        avg_r  <= x_r;
        prod_r <= 1'b1;
      end
      if (cmd.upd) begin
        if (nav > NAV_MAX)
          avg_r <= {1'b0, {(DW-1){1'b1}}};
        else if (nav < NAV_MIN)
          avg_r <= {1'b1, {(DW-1){1'b0}}};
        else
          avg_r <= nav[DW-1:0];
        prod_r <= 1'b1;
      end
      if (cmd.commit) begin
        wp_r <= (int'(wp_r) == DEPTH - 1) ? '0 : wp_r + AW'(1);
        if (cnt_r <= p_eff) cnt_r <= cnt_r + CW'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) x_r <= in_tdata;
    if (cmd.latch_xp) xp_r <= rd_r;
    if (cmd.div_init) begin
      rem_r <= (SW+1)'(a_net);
      er_r  <= sts.div_sat ? EW'(ama_pkg::ONE_Q16) : '0;
    end
    if (cmd.div_step) begin
      if (rem2 >= {1'b0, sum_r}) begin
        rem_r <= rem2 - {1'b0, sum_r};
        er_r  <= {er_r[EW-2:0], 1'b1};
      end else begin
        rem_r <= rem2;
        er_r  <= {er_r[EW-2:0], 1'b0};
      end
    end
    if (cmd.mul1) base_r <= FW'(ama_pkg::SLOW_Q16) + m1[2*FW-1:FW];
    if (cmd.mul2) sc_r <= m2[2*FW-1:FW];
    if (cmd.mul3) prod_mul_r <= PW'($signed({1'b0, sc_r}) * diff);
    if (cmd.commit && prod_r) out_r <= avg_r;
  end

endmodule

`default_nettype wire
